@@ rtl/core/text_console_writer_defines.svh @@
// Assertion macros shared by the console RTL.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Check a property while out of reset.
`define TCW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every edge, reset included.
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/tcw_pkg.sv @@
// Types and constants of the text console writer.
package tcw_pkg;

   localparam int CELLS       = 4096;
   localparam int MAX_COLUMNS = 128;
   localparam int ADDR_W      = $clog2(CELLS);
   localparam int LIM_W       = ADDR_W + 1;
   localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
   localparam int DIV_CNT_W   = $clog2(ADDR_W);
   localparam int POS_W       = 12;

   localparam logic [1:0] OP_PUT     = 2'd0;
   localparam logic [1:0] OP_NEWLINE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   localparam logic [1:0] CSR_COLUMNS      = 2'd0;
   localparam logic [1:0] CSR_SCROLL_LIMIT = 2'd1;
   localparam logic [1:0] CSR_TEXT_ATTR    = 2'd2;

   localparam logic [7:0]  FILL_CHAR     = 8'd0;
   localparam logic [7:0]  FILL_ATTR     = 8'd7;
   localparam logic [7:0]  COLUMNS_RESET = 8'd80;
   localparam logic [12:0] LIMIT_RESET   = 13'd2400;
   localparam logic [7:0]  ATTR_RESET    = 8'd7;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  char_code;
      logic [11:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [11:0] cursor_pos;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } rsp_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic [7:0] attr;
   } cell_type;

endpackage

@@ rtl/core/tcw_ram.sv @@
// Simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/text_console_writer.sv @@
// Text console writer: cell store, cursor, newline and scroll sequencer.
//
//   channel  direction  ports                         word
//   req      in         req_valid req_ready req_data  op, char_code, cell_index
//   rsp      out        rsp_valid rsp_ready rsp_data  cursor_pos, cell_char, cell_attr
//   csr      in         csr_valid csr_ready csr_index csr_data   register write
//
// A put that does not scroll is written straight from idle; a read waits on the registered RAM port;
// newline derives one remainder bit per cycle over the 12 cursor bits. A scroll moves the region up one row,
// one cell per cycle through the single write port of the cell RAM, and a put then writes its cell.
// After reset a clearing pass fills the RAM; no word is taken meanwhile.
// A stalled rsp holds one finished word while the next req word is accepted.
`include "text_console_writer_defines.svh"

module text_console_writer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcw_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [12:0]      csr_data
);

   localparam int ADDR_W    = tcw_pkg::ADDR_W;
   localparam int LIM_W     = tcw_pkg::LIM_W;
   localparam int COL_W     = tcw_pkg::COL_W;
   localparam int DIV_CNT_W = tcw_pkg::DIV_CNT_W;
   localparam int POS_W     = tcw_pkg::POS_W;

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_READ    = 7'b0000100,
      ST_DIVIDE  = 7'b0001000,
      ST_SCROLL  = 7'b0010000,
      ST_WRITE   = 7'b0100000,
      ST_RESPOND = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [7:0]            columns_ff, columns_in;
   logic [12:0]           limit_ff, limit_in;
   logic [7:0]            attr_ff, attr_in;
   logic [ADDR_W-1:0]     cursor_ff, cursor_in;
   logic [LIM_W-1:0]      work_ff, work_in;
   tcw_pkg::req_type      req_ff, req_in;
   logic [COL_W-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [LIM_W-1:0]      scr_ff, scr_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic                  wb_valid_ff, wb_valid_in;
   logic                  wb_move_ff, wb_move_in;
   logic [ADDR_W-1:0]     wb_addr_ff, wb_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type      rsp_ff, rsp_in;
   tcw_pkg::rsp_type      pend_ff, pend_in;

   logic [COL_W-1:0]      cols_eff;
   logic [LIM_W-1:0]      lim_eff;
   logic                  rsp_free;
   logic                  fin;
   tcw_pkg::rsp_type      fin_rsp;
   logic [COL_W:0]        rem_shift;
   logic [COL_W:0]        rem_next;
   logic [LIM_W-1:0]      nl_pos;
   logic [LIM_W-1:0]      scr_src;
   logic [LIM_W-1:0]      back_pos;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   tcw_pkg::cell_type     ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   tcw_pkg::cell_type     ram_rd_data;

   function automatic logic [LIM_W-1:0] row_back(input logic [LIM_W-1:0] pos,
                                                 input logic [COL_W-1:0] cols);
      logic [LIM_W-1:0] c;
      c = LIM_W'(cols);
      return (pos >= c) ? pos - c : '0;
   endfunction

   function automatic logic [ADDR_W-1:0] wrap_cells(input logic [LIM_W-1:0] pos);
      return (32'(pos) >= tcw_pkg::CELLS) ? '0 : ADDR_W'(pos);
   endfunction

   tcw_ram #(
      .WIDTH($bits(tcw_pkg::cell_type)),
      .DEPTH(tcw_pkg::CELLS)
   ) u_cells (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      if (columns_ff == 8'd0) begin
         cols_eff = COL_W'(1);
      end else if (32'(columns_ff) > tcw_pkg::MAX_COLUMNS) begin
         cols_eff = COL_W'(tcw_pkg::MAX_COLUMNS);
      end else begin
         cols_eff = COL_W'(columns_ff);
      end
      if (32'(cols_eff) > tcw_pkg::CELLS) begin
         cols_eff = COL_W'(tcw_pkg::CELLS);
      end
      if (32'(limit_ff) > tcw_pkg::CELLS) begin
         lim_eff = LIM_W'(tcw_pkg::CELLS);
      end else begin
         lim_eff = LIM_W'(limit_ff);
      end
      if (lim_eff < LIM_W'(cols_eff)) begin
         lim_eff = LIM_W'(cols_eff);
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rem_shift = {rem_ff, cursor_ff[div_cnt_ff]};
   assign rem_next  = (rem_shift >= (COL_W+1)'(cols_eff)) ?
                      rem_shift - (COL_W+1)'(cols_eff) : rem_shift;
   assign nl_pos    = LIM_W'(cursor_ff) - LIM_W'(rem_next) + LIM_W'(cols_eff);
   assign scr_src   = scr_ff + LIM_W'(cols_eff);
   assign back_pos  = row_back(work_ff, cols_eff);

   always_comb begin
      columns_in = columns_ff;
      limit_in   = limit_ff;
      attr_in    = attr_ff;
      if (csr_valid) begin
         case (csr_index)
            tcw_pkg::CSR_COLUMNS:      columns_in = csr_data[7:0];
            tcw_pkg::CSR_SCROLL_LIMIT: limit_in   = csr_data;
            tcw_pkg::CSR_TEXT_ATTR:    attr_in    = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      work_in      = work_ff;
      req_in       = req_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      scr_in       = scr_ff;
      clr_in       = clr_ff;
      wb_valid_in  = 1'b0;
      wb_move_in   = wb_move_ff;
      wb_addr_in   = wb_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      fin          = 1'b0;
      fin_rsp      = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '{char_code: tcw_pkg::FILL_CHAR, attr: tcw_pkg::FILL_ATTR};
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(tcw_pkg::CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               case (req_data.op)
                  tcw_pkg::OP_PUT: begin
                     if (LIM_W'(cursor_ff) + LIM_W'(1) >= lim_eff) begin
                        work_in  = LIM_W'(cursor_ff);
                        scr_in   = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = cursor_ff;
                        ram_wr_data = '{char_code: req_data.char_code, attr: attr_ff};
                        cursor_in   = wrap_cells(LIM_W'(cursor_ff) + LIM_W'(1));
                        fin         = 1'b1;
                     end
                  end
                  tcw_pkg::OP_NEWLINE: begin
                     rem_in     = '0;
                     div_cnt_in = DIV_CNT_W'(ADDR_W - 1);
                     state_in   = ST_DIVIDE;
                  end
                  tcw_pkg::OP_READ: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = ADDR_W'(req_data.cell_index);
                     state_in    = ST_READ;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            fin = 1'b1;
            if (32'(req_ff.cell_index) < tcw_pkg::CELLS) begin
               fin_rsp.cell_char = ram_rd_data.char_code;
               fin_rsp.cell_attr = ram_rd_data.attr;
            end
         end
         ST_DIVIDE: begin
            rem_in     = COL_W'(rem_next);
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               if (nl_pos >= lim_eff) begin
                  work_in  = nl_pos;
                  scr_in   = '0;
                  state_in = ST_SCROLL;
               end else begin
                  cursor_in = wrap_cells(nl_pos);
                  fin       = 1'b1;
               end
            end
         end
         ST_SCROLL: begin
            if (wb_valid_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wb_addr_ff;
               ram_wr_data = wb_move_ff ? ram_rd_data :
                             tcw_pkg::cell_type'{char_code: tcw_pkg::FILL_CHAR,
                                                 attr: tcw_pkg::FILL_ATTR};
            end
            if (scr_ff < lim_eff) begin
               wb_valid_in = 1'b1;
               wb_addr_in  = ADDR_W'(scr_ff);
               wb_move_in  = (scr_src < lim_eff);
               ram_rd_en   = (scr_src < lim_eff);
               ram_rd_addr = ADDR_W'(scr_src);
               scr_in      = scr_ff + LIM_W'(1);
            end else if (!wb_valid_ff) begin
               if (req_ff.op == tcw_pkg::OP_PUT) begin
                  work_in  = back_pos;
                  state_in = ST_WRITE;
               end else begin
                  cursor_in = wrap_cells(back_pos);
                  fin       = 1'b1;
               end
            end
         end
         ST_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(work_ff);
            ram_wr_data = '{char_code: req_ff.char_code, attr: attr_ff};
            cursor_in   = wrap_cells(work_ff + LIM_W'(1));
            fin         = 1'b1;
         end
         ST_RESPOND: begin
            if (rsp_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      fin_rsp.cursor_pos = POS_W'(cursor_in);
      if (fin) begin
         if (rsp_free) begin
            rsp_in       = fin_rsp;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            pend_in  = fin_rsp;
            state_in = ST_RESPOND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         columns_ff   <= tcw_pkg::COLUMNS_RESET;
         limit_ff     <= tcw_pkg::LIMIT_RESET;
         attr_ff      <= tcw_pkg::ATTR_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         columns_ff   <= columns_in;
         limit_ff     <= limit_in;
         attr_ff      <= attr_in;
      end
      work_ff    <= work_in;
      req_ff     <= req_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      scr_ff     <= scr_in;
      wb_move_ff <= wb_move_in;
      wb_addr_ff <= wb_addr_in;
      rsp_ff     <= rsp_in;
      pend_ff    <= pend_in;
   end

   `TCW_ASSERT_ALWAYS(a_reset_clears, reset |=> state_ff == ST_CLEAR, "reset did not start the clearing pass")
   `TCW_ASSERT(a_clear_no_rsp, state_ff == ST_CLEAR |-> !rsp_valid_ff, "response during clearing pass")
   `TCW_ASSERT(a_wb_in_scroll, wb_valid_ff |-> state_ff == ST_SCROLL, "scroll write-back outside scroll")
   `TCW_ASSERT(a_respond_holds, state_ff == ST_RESPOND |-> rsp_valid_ff, "pending word without a held word")

endmodule

@@ dv/text_console_writer_check.sv @@
// Checker for the text console writer: predicts each rsp word from the req and csr traffic.
module text_console_writer_check
   import tcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   output int          mismatch_count,
   output int          words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]  char_mem [CELLS];
   logic [7:0]  attr_mem [CELLS];
   int unsigned cursor;
   logic [7:0]  reg_columns;
   logic [12:0] reg_limit;
   logic [7:0]  reg_attr;
   rsp_type     console_rsp_q [$];
   int          fail_total = 0;
   int          pending_n = 0;

   assign mismatch_count = fail_total;
   assign words_pending  = pending_n;

   function automatic int unsigned row_cells();
      int unsigned c;
      c = reg_columns;
      if (c == 0) c = 1;
      if (c > MAX_COLUMNS) c = MAX_COLUMNS;
      if (c > CELLS) c = CELLS;
      return c;
   endfunction

   function automatic int unsigned region_cells(int unsigned cols);
      int unsigned l;
      l = reg_limit;
      if (l > CELLS) l = CELLS;
      if (l < cols) l = cols;
      return l;
   endfunction

   // Move the region up one row, blank the last row, pull the cursor back one row.
   function automatic void scroll_region(int unsigned cols, int unsigned lim);
      for (int unsigned i = 0; i < lim; i++) begin
         if (i < lim - cols) begin
            char_mem[i] = char_mem[i + cols];
            attr_mem[i] = attr_mem[i + cols];
         end else begin
            char_mem[i] = FILL_CHAR;
            attr_mem[i] = FILL_ATTR;
         end
      end
      cursor = (cursor >= cols) ? cursor - cols : 0;
   endfunction

   function automatic rsp_type advance_console(req_type w);
      int unsigned cols;
      int unsigned lim;
      rsp_type     r;
      cols = row_cells();
      lim  = region_cells(cols);
      r    = '0;
      case (w.op)
         OP_PUT: begin
            if (cursor + 1 >= lim) scroll_region(cols, lim);
            char_mem[cursor] = w.char_code;
            attr_mem[cursor] = reg_attr;
            cursor++;
            if (cursor >= CELLS) cursor = 0;
         end
         OP_NEWLINE: begin
            cursor = cursor - cursor % cols + cols;
            if (cursor >= lim) scroll_region(cols, lim);
            if (cursor >= CELLS) cursor = 0;
         end
         OP_READ: begin
            r.cell_char = char_mem[w.cell_index];
            r.cell_attr = attr_mem[w.cell_index];
         end
         default: ;
      endcase
      r.cursor_pos = POS_W'(cursor);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            char_mem[i] = FILL_CHAR;
            attr_mem[i] = FILL_ATTR;
         end
         cursor      = 0;
         reg_columns = COLUMNS_RESET;
         reg_limit   = LIMIT_RESET;
         reg_attr    = ATTR_RESET;
         console_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COLUMNS:      reg_columns = csr_data[7:0];
               CSR_SCROLL_LIMIT: reg_limit   = csr_data;
               CSR_TEXT_ATTR:    reg_attr    = csr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (console_rsp_q.size() == 0) begin
               $display("%0t unexpected rsp word: expected none, actual cursor %0d char %h attr %h",
                        $realtime, rsp_data.cursor_pos, rsp_data.cell_char, rsp_data.cell_attr);
               errs++;
            end else begin
               want = console_rsp_q.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t rsp mismatch: expected cursor %0d char %h attr %h, actual cursor %0d char %h attr %h",
                           $realtime, want.cursor_pos, want.cell_char, want.cell_attr,
                           rsp_data.cursor_pos, rsp_data.cell_char, rsp_data.cell_attr);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) console_rsp_q.push_back(advance_console(req_data));
      end
      fail_total <= fail_total + errs;
      pending_n  <= console_rsp_q.size();
   end

endmodule

@@ dv/text_console_writer_test.sv @@
// Testbench top for the text console writer: clock, reset, stimulus phases and verdict.
module text_console_writer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_data = '0;
   int          mismatch_count;
   int          words_pending;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;
   bit hold_arm = 1'b0;
   int words_sent = 0;
   int settings_used = 0;

   text_console_writer i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   text_console_writer_check i_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatch_count, .words_pending
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #32ms;
      $display("end of test: mismatches");
      $finish;
   end

   // hold off rsp for a long stretch when armed, else stall at the phase rate
   always @(posedge clock) begin
      if (hold_arm) begin
         hold_arm  = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [12:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(logic [12:0] cols, logic [12:0] lim, logic [12:0] attr);
      wait_idle();
      write_reg(CSR_COLUMNS, cols);
      write_reg(CSR_SCROLL_LIMIT, lim);
      write_reg(CSR_TEXT_ATTR, attr);
      write_reg(CSR_UNUSED, 13'($urandom));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic send_word(req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   function automatic req_type random_word(int put_pct, int nl_pct, int read_span);
      req_type w;
      int      r;
      w.char_code  = 8'($urandom);
      w.cell_index = 12'($urandom);
      r = $urandom_range(99);
      if (r < put_pct) w.op = OP_PUT;
      else if (r < put_pct + nl_pct) w.op = OP_NEWLINE;
      else if (r < 96) w.op = OP_READ;
      else w.op = OP_UNUSED;
      if (w.op == OP_READ && $urandom_range(3) != 0)
         w.cell_index = 12'($urandom_range(read_span - 1));
      return w;
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_word('{OP_PUT, 8'h00, 12'hFFF});
      send_word('{OP_PUT, 8'hFF, 12'h000});
      send_word('{OP_NEWLINE, 8'h55, 12'hAAA});
      send_word('{OP_READ, 8'h00, 12'h000});
      send_word('{OP_READ, 8'hFF, 12'h001});
      send_word('{OP_READ, 8'h00, 12'hFFF});
      send_word('{OP_UNUSED, 8'hFF, 12'hFFF});
      send_word('{OP_READ, 8'h00, 12'h002});

      // zero columns, cursor far past a tiny limit
      apply_setting(13'h1F00, 13'd5, 13'h1FFF);
      send_word('{OP_PUT, 8'h41, 12'h000});
      send_word('{OP_NEWLINE, 8'h00, 12'h000});
      send_word('{OP_READ, 8'h00, 12'd79});
      send_word('{OP_READ, 8'h00, 12'd0});

      // saturated columns and limit
      apply_setting(13'h00FF, 13'h1FFF, 13'h005A);
      send_word('{OP_PUT, 8'h7E, 12'h000});
      send_word('{OP_NEWLINE, 8'h00, 12'h000});
      send_word('{OP_NEWLINE, 8'h00, 12'h000});
      send_word('{OP_PUT, 8'h20, 12'h000});
      send_word('{OP_READ, 8'h00, 12'd80});

      // limit below columns
      apply_setting(13'h00FF, 13'd16, 13'h0000);
      send_word('{OP_PUT, 8'h01, 12'h000});
      send_word('{OP_NEWLINE, 8'h00, 12'h000});
      send_word('{OP_READ, 8'h00, 12'd1});
      send_word('{OP_READ, 8'h00, 12'd127});

      apply_setting(13'd4, 13'h1000, 13'h00C3);
      send_word('{OP_PUT, 8'hC3, 12'h000});
      send_word('{OP_NEWLINE, 8'h00, 12'h000});
      send_word('{OP_READ, 8'h00, 12'd0});

      for (int p = 0; p < 14; p++) begin
         int cols;
         int eff;
         int lim;
         int span;
         int nitems;
         int put_pct;
         int nl_pct;
         put_pct = 60;
         nl_pct  = 15;
         nitems  = 90;
         if (p == 12) begin
            cols    = 128;
            lim     = 8191;
            nitems  = 40;
            put_pct = 5;
            nl_pct  = 85;
         end else if (p == 13) begin
            cols   = 1;
            lim    = 4096;
            nitems = 40;
         end else begin
            cols = ($urandom_range(3) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
            eff  = (cols == 0) ? 1 : ((cols > MAX_COLUMNS) ? MAX_COLUMNS : cols);
            lim  = ($urandom_range(5) == 0) ? $urandom_range(0, eff) : eff + $urandom_range(0, 200);
         end
         span = (lim == 0) ? 1 : ((lim > CELLS) ? CELLS : lim);
         apply_setting({5'($urandom), 8'(cols)}, 13'(lim), 13'($urandom));
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 58; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 58; end
            default: begin send_idle_pct = 16; rsp_stall_pct = 16; end
         endcase
         if (p == 0) hold_arm = 1'b1;
         repeat (nitems) send_word(random_word(put_pct, nl_pct, span));
      end

      wait_idle();
      repeat (64) @(posedge clock);
      $display("%0d request words sent across %0d register settings, with idle, stall and hold-off phases",
               words_sent, settings_used);
      $display("settings included zero and saturated columns, oversized and undersized scroll limits");
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
